>>> hdl/cba_pkg.sv
package cba_pkg;

    // Default sizing
    localparam int NUM_UNITS_DEF  = 4096;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ID_WIDTH_DEF   = 32;

    // Field widths
    localparam int BLOCK_ID_W   = 32;
    localparam int BLOCK_SIZE_W = 13;
    localparam int START_UNIT_W = 12;
    localparam int STATUS_W     = 3;
    localparam int POLICY_W     = 2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd5;

    // Placement rules
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Operation kinds
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [BLOCK_ID_W-1:0]   block_id;
        logic [BLOCK_SIZE_W-1:0] block_size;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [START_UNIT_W-1:0] start_unit;
        logic [BLOCK_SIZE_W-1:0] block_length;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic tscan;
        logic rscan;
        logic walk;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_last;
        logic tscan_last;
        logic rscan_last;
        logic walk_last;
        logic go_alloc;
        logic go_free;
        logic run_found;
    } ctrl_sts_t;

endpackage

>>> hdl/contiguous_block_allocator_top.sv
// Channel  | Signals                      | Transfer
// ---------+------------------------------+------------------------------------
// item     | start, busy, item            | edge with start high and busy low
// result   | done, result                 | every edge with done high
// config   | cfg_we, cfg_wdata            | every edge with cfg_we high
//
// After reset the bitmap is cleared one unit a cycle while busy stays high.
// An item scans the block table one slot a cycle, then goes through a decide state.
// An allocate that passes its checks scans the bitmap one unit a cycle and goes through a
// placement state; if a run fits it writes block_size units. A found clear writes the freed
// block's units, one a cycle. A commit state ends the item; done pulses in the cycle after
// commit and the receiver cannot stall.
module contiguous_block_allocator_top #(
    parameter int NUM_UNITS  = cba_pkg::NUM_UNITS_DEF,
    parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF,
    parameter int ID_WIDTH   = cba_pkg::ID_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cba_pkg::POLICY_W-1:0] cfg_wdata,
    input  logic                         start,
    input  cba_pkg::item_t               item,
    output logic                         busy,
    output logic                         done,
    output cba_pkg::result_t             result
);
    import cba_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    cba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    cba_dp #(
        .NUM_UNITS  (NUM_UNITS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .ID_WIDTH   (ID_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result),
        .done      (done)
    );

endmodule

>>> hdl/cba_ctrl.sv
module cba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cba_pkg::ctrl_sts_t sts,
    output cba_pkg::ctrl_cmd_t cmd,
    output logic               busy
);
    import cba_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INIT   = 9'b000000010,
        S_TSCAN  = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_RSCAN  = 9'b000010000,
        S_PLACE  = 9'b000100000,
        S_MARK   = 9'b001000000,
        S_FREE   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Hold state; reset enters the bitmap clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the phases of one operation
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TSCAN;
                end
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TSCAN:
            begin
                cmd.tscan = 1'b1;
                if (sts.tscan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.go_free)
                begin
                    state_next = S_FREE;
                end
                else if (sts.go_alloc)
                begin
                    state_next = S_RSCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RSCAN:
            begin
                cmd.rscan = 1'b1;
                if (sts.rscan_last)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = sts.run_found ? S_MARK : S_DONE;
            end
            S_MARK, S_FREE:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/cba_dp.sv
module cba_dp #(
    parameter int NUM_UNITS  = cba_pkg::NUM_UNITS_DEF,
    parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF,
    parameter int ID_WIDTH   = cba_pkg::ID_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cba_pkg::POLICY_W-1:0]   cfg_wdata,
    input  cba_pkg::item_t                 item,
    input  cba_pkg::ctrl_cmd_t             cmd,
    output cba_pkg::ctrl_sts_t             sts,
    output cba_pkg::result_t               result,
    output logic                           done
);
    import cba_pkg::*;

    localparam int UW   = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int CNTW = UW + 1;
    localparam int SW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SCW  = SW + 1;
    localparam int IDW  = (ID_WIDTH < BLOCK_ID_W) ? ID_WIDTH : BLOCK_ID_W;
    localparam int LW   = (CNTW > BLOCK_SIZE_W) ? CNTW : BLOCK_SIZE_W;

    localparam logic [CNTW-1:0] N_LAST  = CNTW'(NUM_UNITS - 1);
    localparam logic [CNTW-1:0] N_FLUSH = CNTW'(NUM_UNITS + 1);
    localparam logic [CNTW-1:0] N_UNITS = CNTW'(NUM_UNITS);
    localparam logic [SCW-1:0]  T_LAST  = SCW'(MAX_BLOCKS);

    // Storage
    logic                    unit_mem [NUM_UNITS];
    logic [IDW-1:0]          id_mem   [MAX_BLOCKS];
    logic [UW-1:0]           st_mem   [MAX_BLOCKS];
    logic [BLOCK_SIZE_W-1:0] len_mem  [MAX_BLOCKS];

    logic                    bit_q;
    logic [IDW-1:0]          id_q;
    logic [UW-1:0]           st_q;
    logic [BLOCK_SIZE_W-1:0] len_q;

    logic [POLICY_W-1:0]     policy_reg;
    logic                    kind_reg;
    logic [IDW-1:0]          id_reg;
    logic [BLOCK_SIZE_W-1:0] size_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic [SCW-1:0]          tcnt_reg;
    logic [MAX_BLOCKS-1:0]   valid_reg;
    logic                    hit_reg;
    logic [SW-1:0]           hit_slot_reg;
    logic [UW-1:0]           hit_start_reg;
    logic [BLOCK_SIZE_W-1:0] hit_len_reg;
    logic                    free_found_reg;
    logic [SW-1:0]           free_slot_reg;
    logic [CNTW-1:0]         run_len_reg;
    logic [UW-1:0]           run_start_reg;
    logic                    found_reg;
    logic [UW-1:0]           pick_start_reg;
    logic [CNTW-1:0]         pick_len_reg;
    result_t                 res_reg;
    logic                    done_reg;

    logic                    u_we;
    logic                    u_wdata;
    logic [UW-1:0]           u_waddr;
    logic [UW-1:0]           walk_base;
    logic [BLOCK_SIZE_W-1:0] walk_len;
    logic [SW-1:0]           t_eval;
    logic                    t_match;
    logic [CNTW-1:0]         e_idx;
    logic                    e_used;
    logic                    fits;
    logic                    better;
    logic                    size_big;
    logic                    size_zero;
    logic                    ok;
    logic [STATUS_W-1:0]     st_code;
    logic                    tbl_we;

    assign size_zero = (size_reg == '0);
    assign size_big  = (LW'(size_reg) > LW'(N_UNITS));
    assign walk_base = (kind_reg == KIND_CLEAR) ? hit_start_reg : pick_start_reg;
    assign walk_len  = (kind_reg == KIND_CLEAR) ? hit_len_reg : size_reg;

    // Bitmap port: clearing pass or block walk writes, scan reads
    assign u_we    = cmd.init | cmd.walk;
    assign u_wdata = cmd.walk & (kind_reg != KIND_CLEAR);
    assign u_waddr = cmd.init ? cnt_reg[UW-1:0] : UW'(walk_base + cnt_reg[UW-1:0]);

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            unit_mem[u_waddr] <= u_wdata;
        end
        bit_q <= unit_mem[cnt_reg[UW-1:0]];
    end

    // Block table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            id_mem[free_slot_reg]  <= id_reg;
            st_mem[free_slot_reg]  <= pick_start_reg;
            len_mem[free_slot_reg] <= size_reg;
        end
        id_q  <= id_mem[tcnt_reg[SW-1:0]];
        st_q  <= st_mem[tcnt_reg[SW-1:0]];
        len_q <= len_mem[tcnt_reg[SW-1:0]];
    end

    // Table scan compare, one slot behind the read address
    assign t_eval  = SW'(tcnt_reg - 1'b1);
    assign t_match = valid_reg[t_eval] && (id_q == id_reg);

    // Bitmap scan, one unit behind the read address; the final step closes the last run
    assign e_idx  = cnt_reg - 1'b1;
    assign e_used = (cnt_reg == N_FLUSH) | bit_q;
    assign fits   = (LW'(run_len_reg) >= LW'(size_reg));
    always_comb
    begin
        case (policy_reg)
            POL_BEST:  better = !found_reg || (run_len_reg < pick_len_reg);
            POL_WORST: better = !found_reg || (run_len_reg > pick_len_reg);
            default:   better = !found_reg;
        endcase
    end

    // Final status in check order
    always_comb
    begin
        if (kind_reg == KIND_CLEAR)
        begin
            st_code = hit_reg ? ST_OK : ST_NOT_FOUND;
        end
        else if (size_zero)
        begin
            st_code = ST_ZERO;
        end
        else if (hit_reg)
        begin
            st_code = ST_DUP;
        end
        else if (!free_found_reg)
        begin
            st_code = ST_FULL;
        end
        else if (size_big || !found_reg)
        begin
            st_code = ST_OOM;
        end
        else
        begin
            st_code = ST_OK;
        end
    end
    assign ok     = (st_code == ST_OK);
    assign tbl_we = cmd.commit && ok && (kind_reg != KIND_CLEAR);

    // Control and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= '0;
            cnt_reg    <= '0;
            tcnt_reg   <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            done_reg <= cmd.commit;
            if (cmd.init || cmd.rscan || cmd.walk)
            begin
                cnt_reg <= (sts.init_last || sts.rscan_last || sts.walk_last)
                           ? '0 : cnt_reg + 1'b1;
            end
            if (cmd.tscan)
            begin
                tcnt_reg <= sts.tscan_last ? '0 : tcnt_reg + 1'b1;
            end
            if (cmd.commit && ok)
            begin
                if (kind_reg == KIND_CLEAR)
                begin
                    valid_reg[hit_slot_reg] <= 1'b0;
                end
                else
                begin
                    valid_reg[free_slot_reg] <= 1'b1;
                end
            end
        end
    end

    // Operation payload and search results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= item.kind;
            id_reg         <= item.block_id[IDW-1:0];
            size_reg       <= item.block_size;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            run_len_reg    <= '0;
        end
        if (cmd.tscan && tcnt_reg != '0)
        begin
            if (t_match && !hit_reg)
            begin
                hit_reg       <= 1'b1;
                hit_slot_reg  <= t_eval;
                hit_start_reg <= st_q;
                hit_len_reg   <= len_q;
            end
            if (!valid_reg[t_eval] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= t_eval;
            end
        end
        if (cmd.rscan && cnt_reg != '0)
        begin
            if (e_used)
            begin
                if (run_len_reg != '0 && fits && better)
                begin
                    found_reg      <= 1'b1;
                    pick_start_reg <= run_start_reg;
                    pick_len_reg   <= run_len_reg;
                end
                run_len_reg <= '0;
            end
            else
            begin
                if (run_len_reg == '0)
                begin
                    run_start_reg <= e_idx[UW-1:0];
                end
                run_len_reg <= run_len_reg + 1'b1;
            end
        end
        if (cmd.commit)
        begin
            res_reg.status       <= st_code;
            res_reg.start_unit   <= ok ? START_UNIT_W'(walk_base) : '0;
            res_reg.block_length <= ok ? walk_len : '0;
        end
    end

    assign sts.init_last  = cmd.init && (cnt_reg == N_LAST);
    assign sts.tscan_last = cmd.tscan && (tcnt_reg == T_LAST);
    assign sts.rscan_last = cmd.rscan && (cnt_reg == N_FLUSH);
    assign sts.walk_last  = cmd.walk && (LW'(cnt_reg) == LW'(walk_len - 1'b1));
    assign sts.go_alloc   = (kind_reg != KIND_CLEAR) && !size_zero && !hit_reg
                            && free_found_reg && !size_big;
    assign sts.go_free    = (kind_reg == KIND_CLEAR) && hit_reg;
    assign sts.run_found  = found_reg;

    assign result = res_reg;
    assign done   = done_reg;

endmodule

>>> hdl/cba_checker.sv
module cba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input cba_pkg::result_t result
);
    import cba_pkg::*;

    // One result per transfer, never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    // An accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after transfer");

    // Status is a known code
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ST_DUP))
        else $error("status out of range");

    // Errors report an empty block
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.start_unit == '0 && result.block_length == '0))
        else $error("error result not zeroed");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cba_pkg::*;

    localparam int UNITS  = NUM_UNITS_DEF;
    localparam int BLOCKS = MAX_BLOCKS_DEF;

    localparam logic                KIND_ALLOC = 1'b0;
    localparam logic [POLICY_W-1:0] POL_FIRST  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [POLICY_W-1:0] cfg_wdata = '0;
    logic                start = 1'b0;
    item_t               item = '0;
    logic                busy;
    logic                done;
    result_t             result;

    // Allocator image: occupancy, block table and placement rule
    bit                    unit_taken [UNITS];
    bit                    slot_live  [BLOCKS];
    bit [BLOCK_ID_W-1:0]   slot_id    [BLOCKS];
    bit [START_UNIT_W-1:0] slot_start [BLOCKS];
    bit [BLOCK_SIZE_W-1:0] slot_len   [BLOCKS];
    bit [POLICY_W-1:0]     placement;

    result_t pending_results [$];
    int      errors = 0;

    contiguous_block_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int slot_of(input bit [BLOCK_ID_W-1:0] id);
        for (int i = 0; i < BLOCKS; i++)
            if (slot_live[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    // Pick a maximal free run for size units under the current rule
    function automatic bit pick_run(input int size, output int where);
        bit found;
        int pick_start;
        int pick_len;
        int u;
        int run_start;
        int run_len;
        found = 0;
        pick_start = 0;
        pick_len = 0;
        u = 0;
        where = 0;
        while (u < UNITS) begin
            if (unit_taken[u]) begin
                u++;
                continue;
            end
            run_start = u;
            while (u < UNITS && !unit_taken[u])
                u++;
            run_len = u - run_start;
            if (run_len < size)
                continue;
            if (placement == POL_BEST) begin
                if (!found || run_len < pick_len) begin
                    found = 1;
                    pick_start = run_start;
                    pick_len = run_len;
                end
            end else if (placement == POL_WORST) begin
                if (!found || run_len > pick_len) begin
                    found = 1;
                    pick_start = run_start;
                    pick_len = run_len;
                end
            end else begin
                where = run_start;
                return 1;
            end
        end
        where = pick_start;
        return found;
    endfunction

    // Apply one transfer to the image and return its outcome
    function automatic result_t apply_item(input item_t it);
        result_t r;
        int      slot;
        int      free_slot;
        int      where;
        int      size;
        r = '0;
        r.status = ST_OK;
        size = it.block_size;
        if (it.kind == KIND_CLEAR) begin
            slot = slot_of(it.block_id);
            if (slot < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.start_unit = slot_start[slot];
                r.block_length = slot_len[slot];
                for (int k = 0; k < slot_len[slot]; k++)
                    if (slot_start[slot] + k < UNITS)
                        unit_taken[slot_start[slot] + k] = 0;
                slot_live[slot] = 0;
            end
        end else begin
            free_slot = -1;
            for (int i = 0; i < BLOCKS; i++)
                if (!slot_live[i] && free_slot < 0)
                    free_slot = i;
            if (size == 0)
                r.status = ST_ZERO;
            else if (slot_of(it.block_id) >= 0)
                r.status = ST_DUP;
            else if (free_slot < 0)
                r.status = ST_FULL;
            else if (size > UNITS || !pick_run(size, where))
                r.status = ST_OOM;
            else begin
                for (int k = 0; k < size; k++)
                    unit_taken[where + k] = 1;
                slot_live[free_slot] = 1;
                slot_id[free_slot] = it.block_id;
                slot_start[free_slot] = START_UNIT_W'(where);
                slot_len[free_slot] = BLOCK_SIZE_W'(size);
                r.start_unit = START_UNIT_W'(where);
                r.block_length = BLOCK_SIZE_W'(size);
            end
        end
        return r;
    endfunction

    // Check each result against the oldest outcome waiting
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                report("result with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report($sformatf("status %0d, want %0d", result.status, want.status));
                if (result.start_unit !== want.start_unit)
                    report($sformatf("start_unit %0d, want %0d",
                                     result.start_unit, want.start_unit));
                if (result.block_length !== want.block_length)
                    report($sformatf("block_length %0d, want %0d",
                                     result.block_length, want.block_length));
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send(input logic kind, input logic [BLOCK_ID_W-1:0] id,
                        input int size);
        item_t it;
        it.kind = kind;
        it.block_id = id;
        it.block_size = size[BLOCK_SIZE_W-1:0];
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        pending_results.push_back(apply_item(it));
    endtask

    // Drop start for a random stretch, idle_pct in a hundred per cycle
    task automatic idle_gap(input int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off until every outstanding result is in and the block is free
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0 || busy);
    endtask

    task automatic set_policy(input logic [POLICY_W-1:0] pol);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= pol;
        @(posedge clk);
        cfg_we <= 1'b0;
        placement = pol;
    endtask

    // Status codes and field extremes
    task automatic test_status_codes();
        send(KIND_ALLOC, 32'h0, 0);
        send(KIND_ALLOC, 32'hFFFF_FFFF, UNITS);
        send(KIND_ALLOC, 32'h0, 1);
        send(KIND_ALLOC, 32'hFFFF_FFFF, 1);
        send(KIND_CLEAR, 32'h0, 8191);
        send(KIND_CLEAR, 32'hFFFF_FFFF, 0);
        send(KIND_ALLOC, 32'h5, UNITS + 1);
        send(KIND_ALLOC, 32'h6, 8191);
        send(KIND_CLEAR, 32'hFFFF_FFFF, 1);
        drain();
    endtask

    // Holes of 5 and 3 units ahead of a long tail; size 3 lands per rule
    task automatic test_placement();
        int sizes[6] = '{10, 5, 20, 3, 30, 1};
        logic [POLICY_W-1:0] rules[4] = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE};
        for (int i = 0; i < 6; i++)
            send(KIND_ALLOC, 32'(i + 1), sizes[i]);
        send(KIND_CLEAR, 32'd2, 0);
        send(KIND_CLEAR, 32'd4, 0);
        for (int p = 0; p < 4; p++) begin
            set_policy(rules[p]);
            send(KIND_ALLOC, 32'h100, 3);
            send(KIND_CLEAR, 32'h100, 0);
        end
        for (int i = 0; i < 6; i++)
            if (i != 1 && i != 3)
                send(KIND_CLEAR, 32'(i + 1), 0);
        drain();
    endtask

    // Random traffic: mostly allocate and clear of live blocks, some noise
    task automatic test_random(input int count, input int idle_pct);
        int pick;
        int live[$];
        int size;
        for (int n = 0; n < count; n++) begin
            live.delete();
            for (int i = 0; i < BLOCKS; i++)
                if (slot_live[i])
                    live.push_back(i);
            pick = $urandom_range(99);
            if ($urandom_range(99) < 3)
                size = $urandom_range(1000, UNITS);
            else if ($urandom_range(99) < 3)
                size = $urandom_range(0, 8191);
            else
                size = $urandom_range(0, 96);
            if (pick < 45 || live.size() == 0)
                send(KIND_ALLOC, $urandom(), size);
            else if (pick < 85)
                send(KIND_CLEAR, slot_id[live[$urandom_range(live.size() - 1)]],
                     $urandom_range(0, 8191));
            else if (pick < 93)
                send(KIND_CLEAR, $urandom(), size);
            else
                send(KIND_ALLOC, slot_id[live[$urandom_range(live.size() - 1)]], size);
            idle_gap(idle_pct);
        end
    endtask

    initial begin
        int idle_pct[3] = '{0, 50, 13};
        logic [POLICY_W-1:0] rules[4] = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST};
        placement = POL_FIRST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_policy(POL_FIRST);
        test_status_codes();
        test_placement();
        for (int seg = 0; seg < 6; seg++) begin
            set_policy(rules[seg % 4]);
            test_random(230, idle_pct[seg % 3]);
        end
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(64'd800_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cba_pkg.sv
hdl/cba_ctrl.sv
hdl/cba_dp.sv
hdl/contiguous_block_allocator_top.sv
hdl/cba_checker.sv
bench/tb_top.sv
